>>> hw/rtl/m68kea_pkg.sv
package m68kea_pkg;

  // Request kinds
  localparam logic [1:0] REQ_COMPUTE = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_WRITE   = 2'd2;

  // Operand / result kinds
  localparam logic [1:0] KIND_DREG = 2'd0;
  localparam logic [1:0] KIND_AREG = 2'd1;
  localparam logic [1:0] KIND_MEM  = 2'd2;
  localparam logic [1:0] KIND_IMM  = 2'd3;

  // Result status
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BAD = 2'd1;
  localparam logic [1:0] STAT_MEM = 2'd2;

  // Operand sizes (anything above word is long)
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Addressing modes
  localparam logic [2:0] MODE_DREG    = 3'd0;
  localparam logic [2:0] MODE_AREG    = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // Mode 7 sub-modes
  localparam logic [2:0] SUB_ABS_W    = 3'd0;
  localparam logic [2:0] SUB_ABS_L    = 3'd1;
  localparam logic [2:0] SUB_PC_DISP  = 3'd2;
  localparam logic [2:0] SUB_PC_INDEX = 3'd3;
  localparam logic [2:0] SUB_IMM      = 3'd4;

  localparam logic [2:0]  STACK_REG    = 3'd7;
  localparam logic [31:0] MASK_RESET   = 32'h00FF_FFFF;
  localparam int unsigned RF_AW        = 4;   // {address bank, register number}
  localparam int unsigned RF_DEPTH     = 16;

  typedef logic [RF_AW-1:0] rf_addr_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  mode_field;
    logic [2:0]  reg_field;
    logic [1:0]  op_size;
    logic [31:0] pc_in;
    logic [31:0] ext_data;
    logic [1:0]  target_kind;
    logic [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  ea_kind;
    logic [31:0] ea_address;
    logic [2:0]  ea_register;
    logic [2:0]  ea_mode;
    logic [31:0] next_pc;
    logic [31:0] read_data;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        we;
    rf_addr_t    addr;
    logic [31:0] data;
  } rf_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  function automatic logic [31:0] sext16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [31:0] sext8(logic [31:0] v);
    return {{24{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [31:0] size_mask(logic [1:0] size);
    logic [31:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_WORD: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] step_of(logic [1:0] size, logic [2:0] regn);
    logic [2:0] s;
    case (size)
      SIZE_BYTE: s = (regn == STACK_REG) ? 3'd2 : 3'd1;
      SIZE_WORD: s = 3'd2;
      default:   s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/m68kea_rf.sv
module m68kea_rf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  m68kea_pkg::rf_addr_t rd_addr_a_i,
  input  m68kea_pkg::rf_addr_t rd_addr_b_i,
  output logic [31:0]        rd_data_a_o,
  output logic [31:0]        rd_data_b_o,
  input  m68kea_pkg::rf_wr_t wr_i
);
  import m68kea_pkg::*;

  logic [31:0]         mem_q [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid_q;
  logic [31:0]         rd_a_q, rd_b_q;
  logic                rd_a_vld_q, rd_b_vld_q;

  // Storage and registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_a_vld_q <= valid_q[rd_addr_a_i];
        rd_b_vld_q <= valid_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = rd_a_vld_q ? rd_a_q : 32'd0;
  assign rd_data_b_o = rd_b_vld_q ? rd_b_q : 32'd0;

endmodule

>>> hw/rtl/m68kea_calc.sv
module m68kea_calc (
  input  m68kea_pkg::in_item_t  req_i,
  input  logic [31:0]           rd_a_i,
  input  logic [31:0]           rd_b_i,
  input  logic [31:0]           addr_mask_i,
  output m68kea_pkg::out_item_t res_o,
  output m68kea_pkg::rf_wr_t    wr_o
);
  import m68kea_pkg::*;

  logic [1:0]  kind, status;
  logic [31:0] addr, npc, rdata;
  logic [31:0] m, step, idx, brief, dec, pc;
  logic [2:0]  rn;

  always_comb begin
    pc     = req_i.pc_in;
    rn     = req_i.reg_field;
    m      = size_mask(req_i.op_size);
    step   = {29'd0, step_of(req_i.op_size, rn)};
    idx    = req_i.ext_data[11] ? rd_b_i : sext16(rd_b_i);
    brief  = sext8(req_i.ext_data) + idx;
    dec    = rd_a_i - step;
    kind   = KIND_DREG;
    addr   = 32'd0;
    npc    = pc;
    rdata  = 32'd0;
    status = STAT_OK;
    wr_o   = '0;

    case (req_i.req_type)
      REQ_COMPUTE: begin
        case (req_i.mode_field)
          MODE_DREG: kind = KIND_DREG;
          MODE_AREG: kind = KIND_AREG;
          MODE_IND: begin
            kind = KIND_MEM;
            addr = rd_a_i;
          end
          MODE_POSTINC: begin
            kind    = KIND_MEM;
            addr    = rd_a_i;
            wr_o.we   = 1'b1;
            wr_o.addr = {1'b1, rn};
            wr_o.data = rd_a_i + step;
          end
          MODE_PREDEC: begin
            kind    = KIND_MEM;
            addr    = dec;
            wr_o.we   = 1'b1;
            wr_o.addr = {1'b1, rn};
            wr_o.data = dec;
          end
          MODE_DISP: begin
            kind = KIND_MEM;
            addr = rd_a_i + sext16(req_i.ext_data);
            npc  = pc + 32'd2;
          end
          MODE_INDEX: begin
            kind = KIND_MEM;
            addr = rd_a_i + brief;
            npc  = pc + 32'd2;
          end
          default: begin
            case (rn)
              SUB_ABS_W: begin
                kind = KIND_MEM;
                addr = sext16(req_i.ext_data);
                npc  = pc + 32'd2;
              end
              SUB_ABS_L: begin
                kind = KIND_MEM;
                addr = req_i.ext_data;
                npc  = pc + 32'd4;
              end
              SUB_PC_DISP: begin
                kind = KIND_MEM;
                addr = pc + sext16(req_i.ext_data);
                npc  = pc + 32'd2;
              end
              SUB_PC_INDEX: begin
                kind = KIND_MEM;
                addr = pc + brief;
                npc  = pc + 32'd2;
              end
              SUB_IMM: begin
                kind = KIND_IMM;
                if (req_i.op_size == SIZE_BYTE) begin
                  addr = {24'd0, req_i.ext_data[7:0]};
                  npc  = pc + 32'd2;
                end else if (req_i.op_size == SIZE_WORD) begin
                  addr = {16'd0, req_i.ext_data[15:0]};
                  npc  = pc + 32'd2;
                end else begin
                  addr = req_i.ext_data;
                  npc  = pc + 32'd4;
                end
              end
              default: begin
                kind   = KIND_DREG;
                status = STAT_BAD;
              end
            endcase
          end
        endcase
        if (kind == KIND_MEM) begin
          addr = addr & addr_mask_i;
        end
      end
      REQ_READ: begin
        kind = req_i.target_kind;
        case (req_i.target_kind)
          KIND_DREG, KIND_AREG: rdata = rd_a_i & m;
          KIND_MEM:             status = STAT_MEM;
          default: begin
            rdata = req_i.operand_value & m;
            addr  = rdata;
          end
        endcase
      end
      REQ_WRITE: begin
        kind = req_i.target_kind;
        case (req_i.target_kind)
          KIND_DREG: begin
            wr_o.we   = 1'b1;
            wr_o.addr = {1'b0, rn};
            wr_o.data = (rd_a_i & ~m) | (req_i.operand_value & m);
          end
          KIND_AREG: begin
            wr_o.we   = 1'b1;
            wr_o.addr = {1'b1, rn};
            case (req_i.op_size)
              SIZE_BYTE: wr_o.data = sext8(req_i.operand_value);
              SIZE_WORD: wr_o.data = sext16(req_i.operand_value);
              default:   wr_o.data = req_i.operand_value;
            endcase
          end
          KIND_MEM: status = STAT_MEM;
          default:  status = STAT_BAD;
        endcase
      end
      default: status = STAT_BAD;
    endcase

    res_o.ea_kind     = kind;
    res_o.ea_address  = addr;
    res_o.ea_register = rn;
    res_o.ea_mode     = req_i.mode_field;
    res_o.next_pc     = npc;
    res_o.read_data   = rdata;
    res_o.status      = status;
  end

endmodule

>>> hw/rtl/m68k_effective_address_unit.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i/in_stall_o    in_data_i  (m68kea_pkg::in_item_t)
// out      output     out_valid_o/out_stall_i  out_data_o (m68kea_pkg::out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_data_i (address mask, 32 bits)
//
// The accept edge issues the register-file reads, whose ports are registered;
// the compute state that follows computes, writes back and loads the output
// register, with the input stalled. A finished item waits in the output register;
// a stalled output holds the unit in its compute cycle until the register frees.
// Reset (rst_ni low, asynchronous) zeroes all registers through per-entry valid
// bits and restores the address mask to a 24-bit bus; no clearing pass.
module m68k_effective_address_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  m68kea_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output m68kea_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i
);
  import m68kea_pkg::*;

  state_e    state_q, state_d;
  in_item_t  item_q;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic [31:0] mask_q;
  logic      accept, fire;
  rf_addr_t  rd_addr_a, rd_addr_b;
  logic [31:0] rd_a, rd_b;
  rf_wr_t    wr, wr_gated;

  assign accept = in_valid_i && !in_stall_o;

  // Pick the primary operand bank: compute always uses An; read/write follow
  // the target kind. The second port fetches the brief-word index register.
  always_comb begin
    if (in_data_i.req_type == REQ_COMPUTE) begin
      rd_addr_a = {1'b1, in_data_i.reg_field};
    end else begin
      rd_addr_a = {(in_data_i.target_kind == KIND_AREG), in_data_i.reg_field};
    end
    rd_addr_b = {in_data_i.ext_data[15], in_data_i.ext_data[14:12]};
  end

  m68kea_rf u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .wr_i        (wr_gated)
  );

  m68kea_calc u_calc (
    .req_i       (item_q),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .addr_mask_i (mask_q),
    .res_o       (res),
    .wr_o        (wr)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs: stall input while computing, fire once the output slot frees
  always_comb begin
    in_stall_o = 1'b0;
    fire       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EXEC: begin
        in_stall_o = 1'b1;
        fire       = !out_valid_q || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Commit writeback only with the result
  always_comb begin
    wr_gated    = wr;
    wr_gated.we = wr.we && fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mask_q      <= MASK_RESET;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: hold the request, load the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/m68kea_checker.sv
module m68kea_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input m68kea_pkg::out_item_t out_data_o
);
  import m68kea_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted item keeps the input stalled for its compute cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // A new result only appears out of a compute cycle
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without compute cycle");

  // With the output slot empty the compute cycle finishes at once
  a_exec_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> !in_stall_o && out_valid_o)
    else $error("compute cycle did not complete");

endmodule

bind m68k_effective_address_unit m68kea_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb_m68k_effective_address_unit.sv
module tb_m68k_effective_address_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import m68kea_pkg::*;

  // Request code that the block leaves unused; it must still answer it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Gate clears once the block reaches its compute cycle and writes back.
  localparam int unsigned UNIT_LATENCY = 2;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned NUM_PHASES = 5;

  // Shadow register file of the unit, its address mask, and the queue of
  // results still owed by the block.
  class ea_scoreboard;
    logic [31:0] dreg [8];
    logic [31:0] areg [8];
    logic [31:0] addr_mask;
    out_item_t   owed_q [$];
    int unsigned n_requests, n_compute, n_read, n_write, n_unused;
    int unsigned n_checked, n_errors, n_masks;

    function new();
      foreach (dreg[i]) dreg[i] = '0;
      foreach (areg[i]) areg[i] = '0;
      addr_mask = MASK_RESET;
      n_masks = 1;
    endfunction

    function logic [31:0] sx16(logic [31:0] v);
      return {{16{v[15]}}, v[15:0]};
    endfunction

    function logic [31:0] sx8(logic [31:0] v);
      return {{24{v[7]}}, v[7:0]};
    endfunction

    function logic [31:0] width_mask(logic [1:0] size);
      case (size)
        SIZE_BYTE: return 32'h0000_00FF;
        SIZE_WORD: return 32'h0000_FFFF;
        default:   return 32'hFFFF_FFFF;
      endcase
    endfunction

    // Byte steps on the stack pointer stay word aligned.
    function logic [31:0] stride_of(logic [1:0] size, logic [2:0] rn);
      case (size)
        SIZE_BYTE: return (rn == STACK_REG) ? 32'd2 : 32'd1;
        SIZE_WORD: return 32'd2;
        default:   return 32'd4;
      endcase
    endfunction

    // Base plus 8-bit displacement plus index taken from a brief extension word.
    function logic [31:0] brief_index(logic [31:0] base, logic [31:0] ext);
      logic [31:0] idx;
      idx = ext[15] ? areg[ext[14:12]] : dreg[ext[14:12]];
      if (!ext[11]) idx = sx16(idx);
      return base + sx8(ext) + idx;
    endfunction

    function void set_mask(logic [31:0] m);
      addr_mask = m;
      n_masks++;
    endfunction

    // Work out the result of one accepted request and update the shadow state.
    function out_item_t predict_result(in_item_t r);
      out_item_t   e;
      logic [31:0] m;
      logic [2:0]  rn;
      e = '0;
      e.ea_register = r.reg_field;
      e.ea_mode     = r.mode_field;
      e.next_pc     = r.pc_in;
      m  = width_mask(r.op_size);
      rn = r.reg_field;
      case (r.req_type)
        REQ_COMPUTE: begin
          n_compute++;
          e.ea_kind = KIND_MEM;
          case (r.mode_field)
            MODE_DREG: e.ea_kind = KIND_DREG;
            MODE_AREG: e.ea_kind = KIND_AREG;
            MODE_IND:  e.ea_address = areg[rn];
            MODE_POSTINC: begin
              e.ea_address = areg[rn];
              areg[rn] = areg[rn] + stride_of(r.op_size, rn);
            end
            MODE_PREDEC: begin
              areg[rn] = areg[rn] - stride_of(r.op_size, rn);
              e.ea_address = areg[rn];
            end
            MODE_DISP: begin
              e.ea_address = areg[rn] + sx16(r.ext_data);
              e.next_pc = r.pc_in + 32'd2;
            end
            MODE_INDEX: begin
              e.ea_address = brief_index(areg[rn], r.ext_data);
              e.next_pc = r.pc_in + 32'd2;
            end
            default: begin
              case (rn)
                SUB_ABS_W: begin
                  e.ea_address = sx16(r.ext_data);
                  e.next_pc = r.pc_in + 32'd2;
                end
                SUB_ABS_L: begin
                  e.ea_address = r.ext_data;
                  e.next_pc = r.pc_in + 32'd4;
                end
                SUB_PC_DISP: begin
                  e.ea_address = r.pc_in + sx16(r.ext_data);
                  e.next_pc = r.pc_in + 32'd2;
                end
                SUB_PC_INDEX: begin
                  e.ea_address = brief_index(r.pc_in, r.ext_data);
                  e.next_pc = r.pc_in + 32'd2;
                end
                SUB_IMM: begin
                  e.ea_kind = KIND_IMM;
                  if (r.op_size != SIZE_BYTE && r.op_size != SIZE_WORD) begin
                    e.ea_address = r.ext_data;
                    e.next_pc = r.pc_in + 32'd4;
                  end else begin
                    e.ea_address = r.ext_data & width_mask(r.op_size);
                    e.next_pc = r.pc_in + 32'd2;
                  end
                end
                default: begin
                  e.ea_kind = KIND_DREG;
                  e.status = STAT_BAD;
                end
              endcase
            end
          endcase
          if (e.ea_kind == KIND_MEM) e.ea_address = e.ea_address & addr_mask;
        end
        REQ_READ: begin
          n_read++;
          e.ea_kind = r.target_kind;
          case (r.target_kind)
            KIND_DREG: e.read_data = dreg[rn] & m;
            KIND_AREG: e.read_data = areg[rn] & m;
            KIND_MEM:  e.status = STAT_MEM;
            default: begin
              e.read_data  = r.operand_value & m;
              e.ea_address = r.operand_value & m;
            end
          endcase
        end
        REQ_WRITE: begin
          n_write++;
          e.ea_kind = r.target_kind;
          case (r.target_kind)
            KIND_DREG: dreg[rn] = (dreg[rn] & ~m) | (r.operand_value & m);
            KIND_AREG: begin
              case (r.op_size)
                SIZE_BYTE: areg[rn] = sx8(r.operand_value);
                SIZE_WORD: areg[rn] = sx16(r.operand_value);
                default:   areg[rn] = r.operand_value;
              endcase
            end
            KIND_MEM: e.status = STAT_MEM;
            default:  e.status = STAT_BAD;
          endcase
        end
        default: begin
          n_unused++;
          e.status = STAT_BAD;
        end
      endcase
      return e;
    endfunction

    function void note_request(in_item_t r);
      n_requests++;
      owed_q.push_back(predict_result(r));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing pending: %p", got);
        n_errors++;
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      check_field("ea_kind",     32'(want.ea_kind),     32'(got.ea_kind));
      check_field("ea_address",  want.ea_address,       got.ea_address);
      check_field("ea_register", 32'(want.ea_register), 32'(got.ea_register));
      check_field("ea_mode",     32'(want.ea_mode),     32'(got.ea_mode));
      check_field("next_pc",     want.next_pc,          got.next_pc);
      check_field("read_data",   want.read_data,        got.read_data);
      check_field("status",      32'(want.status),      32'(got.status));
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  int unsigned  quiet_cycles = 0;
  ea_scoreboard sb;

  m68k_effective_address_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor: sample every handshake at the rising edge. Check the outgoing
  // result before noting a new request, so a result is never matched against
  // the request accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (cfg_valid_i && cfg_ready_o) sb.set_mask(cfg_data_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end a hung run.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no handshake for %0d cycles, %0d results still pending",
             QUIET_LIMIT, sb.outstanding());
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: switch between stall styles over spans of random length, including
  // stretches with no stall at all and a fixed periodic pattern.
  initial begin
    int unsigned style, span, tick;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 9) < 6);
          default: out_stall_i <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Build one request with a fixed program counter.
  function automatic in_item_t make_req(logic [1:0] req, logic [2:0] mode, logic [2:0] rn,
                                        logic [1:0] size, logic [1:0] kind,
                                        logic [31:0] value, logic [31:0] ext);
    in_item_t r;
    r.req_type      = req;
    r.mode_field    = mode;
    r.reg_field     = rn;
    r.op_size       = size;
    r.pc_in         = 32'h0000_2000;
    r.ext_data      = ext;
    r.target_kind   = kind;
    r.operand_value = value;
    return r;
  endfunction

  // Random request: mostly address computations and register writes, so the
  // computed addresses run on register contents built up by earlier writes.
  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.req_type = REQ_COMPUTE;
    else if (pick < 65) r.req_type = REQ_READ;
    else if (pick < 95) r.req_type = REQ_WRITE;
    else                r.req_type = REQ_UNUSED;
    r.mode_field = 3'($urandom_range(0, 7));
    r.reg_field  = 3'($urandom_range(0, 7));
    r.op_size    = 2'($urandom_range(0, 3));
    // Put the program counter near the top now and then to exercise wrap.
    r.pc_in = ($urandom_range(0, 7) == 0) ? (32'hFFFF_FFF0 | 32'($urandom_range(0, 15)))
                                          : $urandom;
    r.ext_data = $urandom;
    if (r.req_type == REQ_WRITE && $urandom_range(0, 4) != 0)
      r.target_kind = ($urandom_range(0, 1) == 0) ? KIND_DREG : KIND_AREG;
    else
      r.target_kind = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 11))
      0:       r.operand_value = 32'h0000_0000;
      1:       r.operand_value = 32'hFFFF_FFFF;
      2:       r.operand_value = 32'h0000_0080;
      3:       r.operand_value = 32'h0000_8000;
      4:       r.operand_value = 32'h8000_0000;
      default: r.operand_value = $urandom;
    endcase
    return r;
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // on return; the next call or a gap decides what follows.
  task automatic send_item(in_item_t r);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Idle the sender for the given number of cycles with junk on the payload.
  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_data_i  <= random_request();
    end
  endtask

  // Drop valid and wait until every owed result is back, then let the unit
  // settle before the mask is touched.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (UNIT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [31:0] m);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Directed items: merges and sign extension on writes, every addressing
  // mode and sub-mode, and the odd corners of reads and writes.
  task automatic run_directed();
    // Long write with size code three, then byte and word merges.
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd0, 2'd3, KIND_DREG, 32'hFFFF_FFFF, '0));
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd0, SIZE_BYTE, KIND_DREG, 32'h0000_0012, '0));
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd1, SIZE_WORD, KIND_DREG, 32'h0001_8000, '0));
    // Address register writes sign-extend bytes and words.
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd0, SIZE_BYTE, KIND_AREG, 32'h0000_0080, '0));
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd1, SIZE_WORD, KIND_AREG, 32'h1234_7FFF, '0));
    // Writes to memory and to an immediate change nothing.
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd2, 2'd2, KIND_MEM, 32'hDEAD_BEEF, '0));
    send_item(make_req(REQ_WRITE, MODE_DREG, 3'd3, 2'd2, KIND_IMM, 32'hDEAD_BEEF, '0));
    // Reads: register, memory, immediate masked to size.
    send_item(make_req(REQ_READ, MODE_DREG, 3'd0, 2'd3, KIND_DREG, '0, '0));
    send_item(make_req(REQ_READ, MODE_DREG, 3'd0, SIZE_WORD, KIND_AREG, '0, '0));
    send_item(make_req(REQ_READ, MODE_DREG, 3'd4, 2'd2, KIND_MEM, 32'hFFFF_FFFF, '0));
    send_item(make_req(REQ_READ, MODE_DREG, 3'd5, SIZE_BYTE, KIND_IMM, 32'hFFFF_FFFF, '0));
    // Register direct modes and plain indirect.
    send_item(make_req(REQ_COMPUTE, MODE_DREG, 3'd5, 2'd2, KIND_DREG, '0, '0));
    send_item(make_req(REQ_COMPUTE, MODE_AREG, 3'd3, 2'd2, KIND_DREG, '0, '0));
    send_item(make_req(REQ_COMPUTE, MODE_IND, 3'd1, 2'd2, KIND_DREG, '0, '0));
    // Byte post-increment and pre-decrement on the stack pointer step by two.
    send_item(make_req(REQ_COMPUTE, MODE_POSTINC, STACK_REG, SIZE_BYTE, KIND_DREG, '0, '0));
    send_item(make_req(REQ_COMPUTE, MODE_PREDEC, STACK_REG, SIZE_BYTE, KIND_DREG, '0, '0));
    send_item(make_req(REQ_COMPUTE, MODE_PREDEC, 3'd0, 2'd2, KIND_DREG, '0, '0));
    // Negative displacement, word index from A0, long index from D1.
    send_item(make_req(REQ_COMPUTE, MODE_DISP, 3'd1, 2'd2, KIND_DREG, '0, 32'h0000_8000));
    send_item(make_req(REQ_COMPUTE, MODE_INDEX, 3'd1, 2'd2, KIND_DREG, '0, 32'h0000_8080));
    send_item(make_req(REQ_COMPUTE, MODE_INDEX, 3'd0, 2'd2, KIND_DREG, '0, 32'h0000_187F));
    // Mode 7 sub-modes, the immediate at byte and long size, and the invalid ones.
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_ABS_W, 2'd2, KIND_DREG, '0, 32'h0000_8000));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_ABS_L, 2'd2, KIND_DREG, '0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_PC_DISP, 2'd2, KIND_DREG, '0, 32'h0000_FFFE));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_PC_INDEX, 2'd2, KIND_DREG, '0, 32'h0000_9880));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_IMM, SIZE_BYTE, KIND_DREG, '0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, SUB_IMM, 2'd3, KIND_DREG, '0, 32'h8765_4321));
    send_item(make_req(REQ_COMPUTE, MODE_EXT, 3'd5, 2'd2, KIND_DREG, '0, 32'hFFFF_FFFF));
    send_item(make_req(REQ_UNUSED, MODE_EXT, 3'd7, 2'd2, KIND_IMM, 32'hFFFF_FFFF, '1));
  endtask

  // Random items in bursts of random length; the gap size changes now and
  // then, and a gap limit of zero gives stretches with no idling.
  task automatic run_random(int unsigned count);
    int unsigned burst_left, gap_max;
    gap_max    = $urandom_range(0, 6);
    burst_left = $urandom_range(1, 16);
    repeat (count) begin
      send_item(random_request());
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        if (gap_max != 0) idle_sender($urandom_range(1, gap_max));
        if ($urandom_range(0, 3) == 0) gap_max = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  initial begin
    logic [31:0] phase_mask;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // First phase runs on the reset mask; later phases rewrite it while idle,
    // covering all ones, all zeros, a random value and the reset value again.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        case (phase)
          1:       phase_mask = 32'hFFFF_FFFF;
          2:       phase_mask = 32'h0000_0000;
          3:       phase_mask = $urandom;
          default: phase_mask = MASK_RESET;
        endcase
        drain();
        write_mask(phase_mask);
      end
      run_random(ITEMS_PER_PHASE);
    end

    drain();
    repeat (4 * UNIT_LATENCY) @(posedge clk_i);

    $display("Sent %0d requests: %0d address, %0d read, %0d write, %0d unused code.",
             sb.n_requests, sb.n_compute, sb.n_read, sb.n_write, sb.n_unused);
    $display("Checked %0d results under %0d address mask settings, %0d mismatches.",
             sb.n_checked, sb.n_masks, sb.n_errors);
    if (sb.n_errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
